FILE: sv/rtrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtrm_pkg
// Shared types and constants of the radio transmit rate meter.
// ----------------------------------------------------------------------------
package rtrm_pkg;

	localparam int unsigned HEADER_BYTES_DEF  = 3;
	localparam int unsigned MESSAGE_BYTES_DEF = 25;

	localparam int unsigned NUM_CNT    = 8;
	localparam int unsigned CNT_IDX_W  = $clog2(NUM_CNT);
	localparam int unsigned CNT_W      = 32;
	localparam int unsigned CMD_W      = 3;
	localparam int unsigned LEN_W      = 8;
	localparam int unsigned WIN_W      = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// delta * 1000 + elapsed / 2 stays below 2^42
	localparam int unsigned DIV_W      = 42;
	localparam int unsigned DIV_CNT_W  = $clog2(DIV_W);
	localparam int unsigned SCALE_W    = 10;

	// message count by reciprocal multiply, exact for 8-bit lengths and packs up to 64 bytes
	localparam int unsigned MSG_SHIFT  = 16;
	localparam int unsigned MSG_PROD_W = LEN_W + MSG_SHIFT;

	localparam logic [SCALE_W-1:0] RATE_SCALE = SCALE_W'(1000);
	localparam logic [WIN_W-1:0]   WIN_RESET  = WIN_W'(1000);

	typedef enum logic [CMD_W-1:0] {
		CMD_LEGACY = 3'd0,
		CMD_EXT    = 3'd1,
		CMD_BEACON = 3'd2,
		CMD_NAN    = 3'd3,
		CMD_TIME   = 3'd4
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EXT_ADV_EN = 2'd0,
		CFG_BEACON_EN  = 2'd1,
		CFG_NAN_EN     = 2'd2,
		CFG_WIN_LEN    = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL,
		ST_ADD,
		ST_RATE_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

FILE: sv/rtrm_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtrm_in_if
// Input channel: frame events and time samples.
// ----------------------------------------------------------------------------
interface rtrm_in_if;
	import rtrm_pkg::*;

	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [LEN_W-1:0] frame_length;
	logic [CNT_W-1:0] time_ms;

	modport source (output valid, output command, output frame_length, output time_ms,
		input ready);
	modport sink (input valid, input command, input frame_length, input time_ms,
		output ready);
endinterface
`default_nettype wire

FILE: sv/rtrm_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtrm_out_if
// Result channel: window-closed flag and the eight latest rates.
// ----------------------------------------------------------------------------
interface rtrm_out_if;
	import rtrm_pkg::*;

	logic             valid;
	logic             ready;
	logic             window_closed;
	logic [CNT_W-1:0] legacy_frame_rate;
	logic [CNT_W-1:0] legacy_message_rate;
	logic [CNT_W-1:0] ext_frame_rate;
	logic [CNT_W-1:0] ext_message_rate;
	logic [CNT_W-1:0] beacon_frame_rate;
	logic [CNT_W-1:0] beacon_message_rate;
	logic [CNT_W-1:0] nan_frame_rate;
	logic [CNT_W-1:0] nan_message_rate;

	modport source (output valid, output window_closed,
		output legacy_frame_rate, output legacy_message_rate,
		output ext_frame_rate, output ext_message_rate,
		output beacon_frame_rate, output beacon_message_rate,
		output nan_frame_rate, output nan_message_rate,
		input ready);
	modport sink (input valid, input window_closed,
		input legacy_frame_rate, input legacy_message_rate,
		input ext_frame_rate, input ext_message_rate,
		input beacon_frame_rate, input beacon_message_rate,
		input nan_frame_rate, input nan_message_rate,
		output ready);
endinterface
`default_nettype wire

FILE: sv/radio_tx_rate_meter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radio_tx_rate_meter_core
// Frame and message counters with windowed per-second rates on four channels.
// ----------------------------------------------------------------------------
// One item is in work at a time and every item returns exactly one result.
// A frame on any channel, an unused command or a time sample that leaves the
// window open passes through the decode and done states only. A time sample
// that closes the window works through eight rates, each with a multiply
// state, an add state and a division by the single shared restoring divider
// (42 quotient steps and the done flag), the division skipped when the
// elapsed time is zero. A finished result sits in an output register, so
// the next item is taken while it waits; that item then holds in its done
// state until the register is free.
module radio_tx_rate_meter_core #(
	parameter int unsigned HEADER_BYTES  = rtrm_pkg::HEADER_BYTES_DEF,
	parameter int unsigned MESSAGE_BYTES = rtrm_pkg::MESSAGE_BYTES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [rtrm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rtrm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	rtrm_in_if.sink                              in_ch,
	rtrm_out_if.source                           out_ch
);
	import rtrm_pkg::*;

	localparam int unsigned MSG_RECIP = ((1 << MSG_SHIFT) + MESSAGE_BYTES - 1) / MESSAGE_BYTES;

	// configuration
	logic             ext_en_q;
	logic             beacon_en_q;
	logic             nan_en_q;
	logic [WIN_W-1:0] win_len_q;

	// item registers
	logic [CMD_W-1:0] cmd_q;
	logic [LEN_W-1:0] len_q;
	logic [CNT_W-1:0] time_q;
	logic [CNT_W-1:0] elapsed_q;

	// meter state
	logic [CNT_W-1:0] totals_q   [NUM_CNT];
	logic [CNT_W-1:0] open_tot_q [NUM_CNT];
	logic [CNT_W-1:0] rates_q    [NUM_CNT];
	logic [CNT_W-1:0] open_time_q;

	// sequencer
	state_t               state_q;
	state_t               state_n;
	logic [CNT_IDX_W-1:0] idx_q;
	logic                 closed_q;
	logic [DIV_W-1:0]     product_q;
	logic [CNT_W-1:0]     delta_q;

	// result register
	logic             out_valid_q;
	logic             out_closed_q;
	logic [CNT_W-1:0] out_rates_q [NUM_CNT];

	// combinational
	logic             in_xfer;
	logic             out_free;
	logic             frame_go;
	logic             close_go;
	logic             elapsed_zero;
	logic             idx_last;
	logic [CNT_W-1:0] delta_c;
	logic [CNT_W-1:0] rate_sat;
	logic             rate_wr;
	logic [CNT_W-1:0] rate_val;
	logic [CNT_IDX_W-1:0] frame_idx;
	logic [LEN_W-1:0]      pack_len;
	logic [MSG_PROD_W-1:0] msg_prod;
	logic [LEN_W-1:0]      msg_cnt;
	div_req_t         div_req;
	div_rsp_t         div_rsp;

	rtrm_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign in_xfer      = in_ch.valid && (state_q == ST_IDLE);
	assign out_free     = !out_valid_q || out_ch.ready;
	assign elapsed_zero = (elapsed_q == '0);
	assign idx_last     = (idx_q == CNT_IDX_W'(NUM_CNT - 1));
	assign close_go     = (elapsed_q >= CNT_W'(win_len_q));
	assign delta_c      = totals_q[idx_q] - open_tot_q[idx_q];
	assign rate_sat     = (div_rsp.quotient[DIV_W-1:CNT_W] != '0) ? '1
		: div_rsp.quotient[CNT_W-1:0];
	assign frame_idx    = {cmd_q[1:0], 1'b0};

	// short packs below the header give no messages
	assign pack_len = (len_q >= LEN_W'(HEADER_BYTES)) ? len_q - LEN_W'(HEADER_BYTES) : '0;
	assign msg_prod = MSG_PROD_W'(pack_len) * MSG_PROD_W'(MSG_RECIP);
	assign msg_cnt  = msg_prod[MSG_PROD_W-1:MSG_SHIFT];

	always_comb begin
		unique case (cmd_q)
			CMD_EXT:    frame_go = ext_en_q;
			CMD_BEACON: frame_go = beacon_en_q;
			CMD_NAN:    frame_go = nan_en_q;
			default:    frame_go = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) state_n = ST_DECODE;
			end
			ST_DECODE: begin
				if ((cmd_q == CMD_TIME) && close_go) begin
					state_n = ST_MUL;
				end else begin
					state_n = ST_DONE;
				end
			end
			ST_MUL: begin
				state_n = ST_ADD;
			end
			ST_ADD: begin
				if (!elapsed_zero) begin
					state_n = ST_RATE_DIV;
				end else begin
					state_n = idx_last ? ST_DONE : ST_MUL;
				end
			end
			ST_RATE_DIV: begin
				if (div_rsp.done) state_n = idx_last ? ST_DONE : ST_MUL;
			end
			ST_DONE: begin
				if (out_free) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = elapsed_q;
		rate_wr          = 1'b0;
		rate_val         = delta_q;
		unique case (state_q)
			ST_ADD: begin
				div_req.start    = !elapsed_zero;
				div_req.dividend = product_q + DIV_W'(elapsed_q >> 1);
				div_req.divisor  = elapsed_q;
				// zero elapsed time passes the raw delta
				rate_wr          = elapsed_zero;
			end
			ST_RATE_DIV: begin
				div_req.divisor = elapsed_q;
				rate_wr         = div_rsp.done;
				rate_val        = rate_sat;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_en_q    <= 1'b0;
			beacon_en_q <= 1'b0;
			nan_en_q    <= 1'b0;
			win_len_q   <= WIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_EXT_ADV_EN: ext_en_q    <= cfg_wdata[0];
				CFG_BEACON_EN:  beacon_en_q <= cfg_wdata[0];
				CFG_NAN_EN:     nan_en_q    <= cfg_wdata[0];
				CFG_WIN_LEN:    win_len_q   <= cfg_wdata[WIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q     <= in_ch.command;
			len_q     <= in_ch.frame_length;
			time_q    <= in_ch.time_ms;
			elapsed_q <= in_ch.time_ms - open_time_q;
		end
		if (state_q == ST_MUL) begin
			delta_q   <= delta_c;
			product_q <= DIV_W'(delta_c) * DIV_W'(RATE_SCALE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CNT; i++) begin
				totals_q[i]   <= '0;
				open_tot_q[i] <= '0;
				rates_q[i]    <= '0;
			end
			open_time_q <= '0;
			idx_q       <= '0;
			closed_q    <= 1'b0;
		end else begin
			if (in_xfer) begin
				idx_q    <= '0;
				closed_q <= 1'b0;
			end
			if ((state_q == ST_DECODE) && (cmd_q == CMD_LEGACY)) begin
				totals_q[0] <= totals_q[0] + CNT_W'(1);
				totals_q[1] <= totals_q[1] + CNT_W'(1);
			end
			if ((state_q == ST_DECODE) && frame_go) begin
				totals_q[frame_idx]        <= totals_q[frame_idx] + CNT_W'(1);
				totals_q[frame_idx | 3'd1] <= totals_q[frame_idx | 3'd1]
					+ CNT_W'(msg_cnt);
			end
			if (rate_wr) begin
				rates_q[idx_q]    <= rate_val;
				open_tot_q[idx_q] <= totals_q[idx_q];
				idx_q             <= idx_q + CNT_IDX_W'(1);
				if (idx_last) begin
					open_time_q <= time_q;
					closed_q    <= 1'b1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			out_closed_q <= closed_q;
			for (int i = 0; i < NUM_CNT; i++) begin
				out_rates_q[i] <= rates_q[i];
			end
		end
	end

	assign out_ch.valid               = out_valid_q;
	assign out_ch.window_closed       = out_closed_q;
	assign out_ch.legacy_frame_rate   = out_rates_q[0];
	assign out_ch.legacy_message_rate = out_rates_q[1];
	assign out_ch.ext_frame_rate      = out_rates_q[2];
	assign out_ch.ext_message_rate    = out_rates_q[3];
	assign out_ch.beacon_frame_rate   = out_rates_q[4];
	assign out_ch.beacon_message_rate = out_rates_q[5];
	assign out_ch.nan_frame_rate      = out_rates_q[6];
	assign out_ch.nan_message_rate    = out_rates_q[7];

endmodule
`default_nettype wire

FILE: sv/rtrm_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtrm_divider
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module rtrm_divider (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rtrm_pkg::div_req_t req,
	output rtrm_pkg::div_rsp_t      rsp
);
	import rtrm_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [CNT_W-1:0]     div_q;

	logic [CNT_W:0]       rem_sh;
	logic                 q_bit;
	logic [CNT_W-1:0]     rem_n;

	always_comb begin
		rem_sh = {rem_q, quo_q[DIV_W-1]};
		q_bit  = (rem_sh >= {1'b0, div_q});
		rem_n  = q_bit ? CNT_W'(rem_sh - {1'b0, div_q}) : rem_sh[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + DIV_CNT_W'(1);
				end
			end
		end
	end

	// dividend shifts out at the top while quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[DIV_W-2:0], q_bit};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
`default_nettype wire

FILE: verif/radio_tx_rate_meter_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_tx_rate_meter_core_test
// Drives frame events and time samples into the rate meter under random
// input gaps and output stalls, predicts every result from an internal model
// of the counters and the window logic, and checks each result field by field.
// ----------------------------------------------------------------------------
module radio_tx_rate_meter_core_test;
	import rtrm_pkg::*;

	localparam int unsigned SETTLE_CYCLES = 400;
	localparam int unsigned PHASE_EVENTS  = 250;

	typedef struct packed {
		logic             wait_idle;
		logic [CMD_W-1:0] command;
		logic [LEN_W-1:0] frame_length;
		logic [CNT_W-1:0] time_ms;
	} tx_event_t;

	typedef struct packed {
		logic                          closed;
		logic [NUM_CNT-1:0][CNT_W-1:0] rate;
	} rate_report_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	rtrm_in_if  in_bus ();
	rtrm_out_if out_bus ();

	radio_tx_rate_meter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_bus),
		.out_ch    (out_bus)
	);

	always #5 clk = ~clk;

	string field_names [NUM_CNT+1] = '{"window_closed",
		"legacy_frame_rate", "legacy_message_rate", "ext_frame_rate", "ext_message_rate",
		"beacon_frame_rate", "beacon_message_rate", "nan_frame_rate", "nan_message_rate"};

	tx_event_t    pending_events [$];
	rate_report_t rate_reports_due [$];

	// meter model: configuration and counter state
	logic             ext_en, beacon_en, nan_en;
	logic [WIN_W-1:0] win_ms;
	logic [CNT_W-1:0] run_total [NUM_CNT];
	logic [CNT_W-1:0] open_total [NUM_CNT];
	logic [CNT_W-1:0] cur_rate [NUM_CNT];
	logic [CNT_W-1:0] open_ms;

	// where the generator believes the window opened, to aim samples at its edge
	logic [CNT_W-1:0] sample_open_ms;
	bit               hold_next;

	int unsigned mismatches;
	int unsigned results_seen;
	bit          long_hold_done;

	function automatic logic [CNT_W-1:0] msg_count(logic [LEN_W-1:0] len);
		if (len < HEADER_BYTES_DEF + MESSAGE_BYTES_DEF)
			return '0;
		return (CNT_W'(len) - HEADER_BYTES_DEF) / MESSAGE_BYTES_DEF;
	endfunction

	function automatic logic [CNT_W-1:0] scaled_rate(logic [CNT_W-1:0] delta,
		logic [CNT_W-1:0] elapsed);
		logic [63:0] q;
		if (elapsed == 0)
			return delta;
		q = (64'(delta) * 64'd1000 + 64'(elapsed / 2)) / 64'(elapsed);
		if (q > 64'hFFFF_FFFF)
			return '1;
		return q[CNT_W-1:0];
	endfunction

	function automatic void tally(int unsigned chan, logic [CNT_W-1:0] msgs);
		run_total[2*chan]   = run_total[2*chan] + 1;
		run_total[2*chan+1] = run_total[2*chan+1] + msgs;
	endfunction

	function automatic rate_report_t predict_report(tx_event_t ev);
		rate_report_t     rep;
		logic [CNT_W-1:0] elapsed;
		rep.closed = 1'b0;
		case (ev.command)
			CMD_LEGACY: tally(0, 1);
			CMD_EXT:    if (ext_en) tally(1, msg_count(ev.frame_length));
			CMD_BEACON: if (beacon_en) tally(2, msg_count(ev.frame_length));
			CMD_NAN:    if (nan_en) tally(3, msg_count(ev.frame_length));
			CMD_TIME: begin
				elapsed = ev.time_ms - open_ms;
				if (elapsed >= CNT_W'(win_ms)) begin
					for (int i = 0; i < NUM_CNT; i++) begin
						cur_rate[i]   = scaled_rate(run_total[i] - open_total[i], elapsed);
						open_total[i] = run_total[i];
					end
					open_ms    = ev.time_ms;
					rep.closed = 1'b1;
				end
			end
			default: ;
		endcase
		for (int i = 0; i < NUM_CNT; i++)
			rep.rate[i] = cur_rate[i];
		return rep;
	endfunction

	// mostly no pause, some short, a few long
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 40);
		return $urandom_range(100, 300);
	endfunction

	// ---------------- sender ----------------
	int unsigned send_gap;
	int unsigned send_calm;

	always @(posedge clk or negedge arst_n) begin : drive_events
		bit        offer;
		tx_event_t head;
		if (!arst_n) begin
			in_bus.valid <= 1'b0;
			send_gap = 0;
			send_calm = 0;
		end else begin
			offer = in_bus.valid;
			if (in_bus.valid && in_bus.ready) begin
				head = pending_events.pop_front();
				rate_reports_due.push_back(predict_report(head));
				offer = 1'b0;
				if (send_calm > 0)
					send_calm--;
				else
					send_gap = gap_len();
				if ($urandom_range(0, 199) == 0)
					send_calm = $urandom_range(30, 150);
			end
			if (!offer) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_events.size() != 0 &&
					(!pending_events[0].wait_idle || rate_reports_due.size() == 0)) begin
					head = pending_events[0];
					in_bus.command      <= head.command;
					in_bus.frame_length <= head.frame_length;
					in_bus.time_ms      <= head.time_ms;
					offer = 1'b1;
				end
			end
			in_bus.valid <= offer;
		end
	end

	// ---------------- receiver ----------------
	int unsigned stall_left;
	int unsigned recv_calm;

	always @(posedge clk or negedge arst_n) begin : pace_results
		if (!arst_n) begin
			out_bus.ready <= 1'b0;
			stall_left = 0;
			recv_calm = 0;
		end else begin
			// one long hold-off so the block backs up into its input
			if (!long_hold_done && results_seen >= 300) begin
				long_hold_done = 1'b1;
				stall_left = 3000;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_bus.ready <= 1'b0;
			end else if (recv_calm > 0) begin
				recv_calm--;
				out_bus.ready <= 1'b1;
			end else begin
				if ($urandom_range(0, 299) == 0)
					recv_calm = $urandom_range(200, 1500);
				if ($urandom_range(0, 15) == 0)
					stall_left = gap_len();
				out_bus.ready <= (stall_left == 0);
			end
		end
	end

	always @(posedge clk) begin : check_results
		rate_report_t     seen;
		rate_report_t     want;
		logic [CNT_W-1:0] want_v;
		logic [CNT_W-1:0] seen_v;
		if (arst_n && out_bus.valid && out_bus.ready) begin
			seen.closed  = out_bus.window_closed;
			seen.rate[0] = out_bus.legacy_frame_rate;
			seen.rate[1] = out_bus.legacy_message_rate;
			seen.rate[2] = out_bus.ext_frame_rate;
			seen.rate[3] = out_bus.ext_message_rate;
			seen.rate[4] = out_bus.beacon_frame_rate;
			seen.rate[5] = out_bus.beacon_message_rate;
			seen.rate[6] = out_bus.nan_frame_rate;
			seen.rate[7] = out_bus.nan_message_rate;
			results_seen++;
			if (rate_reports_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual closed=%0b rates=%h",
					$time, seen.closed, seen.rate);
				mismatches++;
			end else begin
				want = rate_reports_due.pop_front();
				for (int f = 0; f <= NUM_CNT; f++) begin
					want_v = (f == 0) ? CNT_W'(want.closed) : want.rate[f-1];
					seen_v = (f == 0) ? CNT_W'(seen.closed) : seen.rate[f-1];
					if (want_v !== seen_v) begin
						$display("%0t: %s expected %0d actual %0d",
							$time, field_names[f], want_v, seen_v);
						mismatches++;
					end
				end
			end
		end
	end

	// ---------------- stimulus ----------------
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
	endtask

	task automatic program_meter(bit ext, bit bcn, bit nan_on, logic [WIN_W-1:0] win);
		write_reg(CFG_EXT_ADV_EN, CFG_DATA_W'(ext));
		write_reg(CFG_BEACON_EN, CFG_DATA_W'(bcn));
		write_reg(CFG_NAN_EN, CFG_DATA_W'(nan_on));
		write_reg(CFG_WIN_LEN, CFG_DATA_W'(win));
		@(posedge clk);
		cfg_we <= 1'b0;
		ext_en    = ext;
		beacon_en = bcn;
		nan_en    = nan_on;
		win_ms    = win;
	endtask

	// block is idle once every result is back and the sender queue is empty
	task automatic settle();
		while (pending_events.size() != 0 || rate_reports_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_event(logic [CMD_W-1:0] cmd, logic [LEN_W-1:0] len,
		logic [CNT_W-1:0] t);
		tx_event_t ev;
		ev.wait_idle    = hold_next;
		ev.command      = cmd;
		ev.frame_length = len;
		ev.time_ms      = t;
		hold_next = 1'b0;
		if (cmd == CMD_TIME && t - sample_open_ms >= CNT_W'(win_ms))
			sample_open_ms = t;
		pending_events.push_back(ev);
	endtask

	function automatic logic [LEN_W-1:0] pick_length();
		int unsigned v;
		if ($urandom_range(0, 1) == 0)
			return LEN_W'($urandom_range(0, 255));
		// lengths around the message boundaries
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = 3;
			2: v = 27;
			3: v = 28;
			4: v = 52;
			5: v = 53;
			6: v = 77;
			7: v = 78;
			8: v = 253;
			default: v = 255;
		endcase
		return LEN_W'(v);
	endfunction

	task automatic queue_sample();
		logic [CNT_W-1:0] w;
		logic [CNT_W-1:0] t;
		w = CNT_W'(win_ms);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: t = sample_open_ms + w + $urandom_range(0, w / 4);
			4:          t = sample_open_ms + w;
			5:          t = sample_open_ms + w - 1;
			6, 7:       t = sample_open_ms + $urandom_range(0, w - 1);
			8:          t = sample_open_ms + $urandom_range(w, 32'hFFFF_FFFF);
			default:    t = $urandom();
		endcase
		queue_event(CMD_TIME, LEN_W'($urandom_range(0, 255)), t);
	endtask

	task automatic queue_random_event();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 22)
			queue_event(CMD_LEGACY, LEN_W'($urandom_range(0, 255)), $urandom());
		else if (r < 36)
			queue_event(CMD_EXT, pick_length(), $urandom());
		else if (r < 50)
			queue_event(CMD_BEACON, pick_length(), $urandom());
		else if (r < 64)
			queue_event(CMD_NAN, pick_length(), $urandom());
		else if (r < 93)
			queue_sample();
		else
			queue_event(CMD_W'($urandom_range(5, 7)), LEN_W'($urandom_range(0, 255)),
				$urandom());
	endtask

	initial begin : run_test
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = CFG_EXT_ADV_EN;
		cfg_wdata           = '0;
		in_bus.valid        = 1'b0;
		in_bus.command      = CMD_LEGACY;
		in_bus.frame_length = '0;
		in_bus.time_ms      = '0;
		out_bus.ready       = 1'b0;
		ext_en         = 1'b0;
		beacon_en      = 1'b0;
		nan_en         = 1'b0;
		win_ms         = WIN_RESET;
		open_ms        = '0;
		sample_open_ms = '0;
		hold_next      = 1'b0;
		mismatches     = 0;
		results_seen   = 0;
		long_hold_done = 1'b0;
		for (int i = 0; i < NUM_CNT; i++) begin
			run_total[i]  = '0;
			open_total[i] = '0;
			cur_rate[i]   = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: only legacy frames count
		program_meter(1'b0, 1'b0, 1'b0, 16'd1000);
		queue_event(CMD_LEGACY, 8'hFF, 32'hFFFF_FFFF);
		queue_event(CMD_LEGACY, 8'h00, 32'h0000_0000);
		queue_event(CMD_EXT, 8'd200, 32'd0);
		queue_event(CMD_BEACON, 8'd255, 32'd0);
		queue_event(CMD_NAN, 8'd100, 32'd0);
		queue_event(3'd5, 8'hAA, 32'h5555_5555);
		queue_event(3'd6, 8'h55, 32'hAAAA_AAAA);
		queue_event(3'd7, 8'hFF, 32'hFFFF_FFFF);
		queue_event(CMD_TIME, 8'd0, 32'd999);
		queue_event(CMD_TIME, 8'd0, 32'd1000);
		settle();

		// all channels on, lengths at the message boundaries, wrapping time
		program_meter(1'b1, 1'b1, 1'b1, 16'd1000);
		queue_event(CMD_EXT, 8'd27, 32'd0);
		queue_event(CMD_EXT, 8'd28, 32'd0);
		queue_event(CMD_BEACON, 8'd52, 32'd0);
		queue_event(CMD_BEACON, 8'd53, 32'd0);
		queue_event(CMD_NAN, 8'd255, 32'd0);
		queue_event(CMD_NAN, 8'd0, 32'd0);
		queue_event(CMD_LEGACY, 8'd0, 32'd0);
		queue_event(CMD_TIME, 8'd0, 32'd1999);
		queue_event(CMD_TIME, 8'd0, 32'hFFFF_FFFF);
		queue_event(CMD_TIME, 8'd0, 32'd999);
		settle();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: program_meter(1'b1, 1'b1, 1'b1, 16'hFFFF);
				1: program_meter(1'b0, 1'b1, 1'b0, 16'd1000);
				2: program_meter(1'b1, 1'b0, 1'b1, WIN_W'($urandom_range(1000, 65535)));
				3: program_meter(1'b1, 1'b1, 1'b1, 16'd1000);
				4: program_meter(1'b0, 1'b0, 1'b0, WIN_W'($urandom_range(1000, 65535)));
				default: program_meter(1'b1, 1'b1, 1'b1, WIN_W'($urandom_range(1000, 65535)));
			endcase
			for (int n = 0; n < PHASE_EVENTS; n++) begin
				// sender waits for every result before this one
				if (n == PHASE_EVENTS / 2)
					hold_next = 1'b1;
				queue_random_event();
			end
			settle();
		end

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin : watchdog
		#(64'd100_000_000);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
